// ----- hw/rtl/kms_pkg.sv -----
// Shared constants, types and helper functions for the keypad matrix scanner.
`default_nettype none

package kms_pkg;

    localparam int ROWS        = 4;
    localparam int COLS        = 4;
    localparam int COUNT_WIDTH = 16;

    localparam int ROW_WIDTH       = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam int LEVEL_WIDTH     = 4;
    localparam int MASK_WIDTH      = 4;
    localparam int OUT_ROW_WIDTH   = 2;
    localparam int TIME_WIDTH      = 16;
    localparam int CFG_INDEX_WIDTH = 8;
    localparam int S_TDATA_WIDTH   = 8;
    localparam int M_TDATA_WIDTH   = 16;

    localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = '1;

    localparam logic [CFG_INDEX_WIDTH-1:0] REG_PRESS_TIME = 8'd0;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_HOLD_TIME  = 8'd1;

    localparam logic [TIME_WIDTH-1:0] PRESS_TIME_RESET = 16'd1;
    localparam logic [TIME_WIDTH-1:0] HOLD_TIME_RESET  = 16'd40;

    localparam logic [MASK_WIDTH-1:0] DRIVE_NONE = 4'hF;

    typedef logic [COLS-1:0][COUNT_WIDTH-1:0] count_row_t;
    typedef logic [ROW_WIDTH-1:0]             row_t;

    function automatic row_t next_row(input row_t row);
        row_t result;
        if (32'(row) >= ROWS - 1)
        begin
            result = '0;
        end
        else
        begin
            result = row_t'(32'(row) + 1);
        end
        return result;
    endfunction

    function automatic logic [MASK_WIDTH-1:0] drive_pattern(input row_t row);
        logic [MASK_WIDTH-1:0] result;
        result = DRIVE_NONE;
        if (32'(row) < MASK_WIDTH)
        begin
            result[row] = 1'b0;
        end
        return result;
    endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/keypad_matrix_scanner.sv -----
// Top level of the keypad matrix scanner with per-key duration counters in a row memory.
`default_nettype none

// The block scans a key matrix one row per input beat. Each beat on the s_axis
// channel carries the active-low column levels sensed while the current row was
// driven low. Each beat on the m_axis channel reports that row, the keys whose
// duration counter just reached press_time or hold_time, and the active-low
// drive pattern for the next row to scan.
// The counters sit in a row-wide memory with a registered read. A beat
// is read on acceptance and written back when it leaves the read stage,
// and a write that meets a read of the same row is forwarded.
// The block takes one beat per cycle as long as the output side is ready.
// When the receiver stalls, one result waits in the output register and one
// more in the read stage before s_axis_tready falls.
// Reset clears all counters through per-row valid bits, sets the row to zero,
// press_time to 1 and hold_time to 40.
// The configuration channel is always ready. Writes to an unknown index are
// ignored, and writes are meant for idle periods only.
module keypad_matrix_scanner (
    input  wire                               clk,
    input  wire                               rst_n,
    input  wire                               s_axis_tvalid,
    output logic                              s_axis_tready,
    // Bits 3:0 column_levels, bits 7:4 zero.
    input  wire  [kms_pkg::S_TDATA_WIDTH-1:0] s_axis_tdata,
    output logic                              m_axis_tvalid,
    input  wire                               m_axis_tready,
    // Bits 1:0 scanned_row, 5:2 pressed_mask, 9:6 hold_mask, 13:10 row_drive,
    // 15:14 zero.
    output logic [kms_pkg::M_TDATA_WIDTH-1:0] m_axis_tdata,
    input  wire                               cfg_valid,
    output logic                              cfg_ready,
    input  wire  [kms_pkg::CFG_INDEX_WIDTH-1:0] cfg_index,
    input  wire  [kms_pkg::TIME_WIDTH-1:0]    cfg_data
);

    import kms_pkg::*;

    logic [TIME_WIDTH-1:0] press_time_reg;
    logic [TIME_WIDTH-1:0] hold_time_reg;

    row_t       row_index_reg;
    logic       s1_valid_reg;
    row_t       s1_row_reg;
    logic [LEVEL_WIDTH-1:0] s1_levels_reg;
    logic       rd_valid_reg;
    logic       fwd_sel_reg;
    count_row_t fwd_data_reg;
    count_row_t rd_data_reg;
    logic [ROWS-1:0] row_valid_reg;

    count_row_t mem [ROWS];

    logic                  m_valid_reg;
    logic [OUT_ROW_WIDTH-1:0] m_row_reg;
    logic [MASK_WIDTH-1:0] m_pressed_reg;
    logic [MASK_WIDTH-1:0] m_hold_reg;
    logic [MASK_WIDTH-1:0] m_drive_reg;

    logic       s_accept;
    logic       s1_adv;
    logic       wr_en;
    logic       fwd_hit;
    count_row_t cur_counts;
    count_row_t new_counts;
    logic [MASK_WIDTH-1:0] pressed_mask;
    logic [MASK_WIDTH-1:0] hold_mask;

    assign cfg_ready     = 1'b1;
    assign s1_adv        = !m_valid_reg || m_axis_tready;
    assign s_axis_tready = !s1_valid_reg || s1_adv;
    assign s_accept      = s_axis_tvalid && s_axis_tready;
    assign wr_en         = s1_valid_reg && s1_adv;
    assign fwd_hit       = wr_en && (s1_row_reg == row_index_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            press_time_reg <= PRESS_TIME_RESET;
            hold_time_reg  <= HOLD_TIME_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_PRESS_TIME: press_time_reg <= cfg_data;
                REG_HOLD_TIME:  hold_time_reg  <= cfg_data;
                default:        ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[s1_row_reg] <= new_counts;
        end
        if (s_accept)
        begin
            rd_data_reg <= mem[row_index_reg];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_index_reg <= '0;
            s1_valid_reg  <= 1'b0;
            row_valid_reg <= '0;
            rd_valid_reg  <= 1'b0;
            fwd_sel_reg   <= 1'b0;
        end
        else
        begin
            if (wr_en)
            begin
                row_valid_reg[s1_row_reg] <= 1'b1;
            end
            if (s_accept)
            begin
                row_index_reg <= next_row(row_index_reg);
                rd_valid_reg  <= row_valid_reg[row_index_reg];
                fwd_sel_reg   <= fwd_hit;
                s1_valid_reg  <= 1'b1;
            end
            else if (s1_adv)
            begin
                s1_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_accept)
        begin
            s1_row_reg    <= row_index_reg;
            s1_levels_reg <= s_axis_tdata[LEVEL_WIDTH-1:0];
            fwd_data_reg  <= new_counts;
        end
    end

    always_comb
    begin
        logic down;
        logic [COUNT_WIDTH-1:0] inc;
        if (fwd_sel_reg)
        begin
            cur_counts = fwd_data_reg;
        end
        else if (rd_valid_reg)
        begin
            cur_counts = rd_data_reg;
        end
        else
        begin
            cur_counts = '0;
        end
        new_counts   = cur_counts;
        pressed_mask = '0;
        hold_mask    = '0;
        for (int c = 0; c < COLS; c++)
        begin
            down = (c < LEVEL_WIDTH) ? !s1_levels_reg[c % LEVEL_WIDTH] : 1'b0;
            inc  = cur_counts[c] + 1'b1;
            if (!down)
            begin
                new_counts[c] = '0;
            end
            else if (cur_counts[c] != COUNT_MAX)
            begin
                new_counts[c] = inc;
                if (c < MASK_WIDTH)
                begin
                    if (32'(inc) == 32'(press_time_reg))
                    begin
                        pressed_mask[c % MASK_WIDTH] = 1'b1;
                    end
                    if (32'(inc) == 32'(hold_time_reg))
                    begin
                        hold_mask[c % MASK_WIDTH] = 1'b1;
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_valid_reg <= 1'b0;
        end
        else if (s1_adv)
        begin
            m_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            m_row_reg     <= OUT_ROW_WIDTH'(s1_row_reg);
            m_pressed_reg <= pressed_mask;
            m_hold_reg    <= hold_mask;
            m_drive_reg   <= drive_pattern(next_row(s1_row_reg));
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = {2'b00, m_drive_reg, m_hold_reg, m_pressed_reg, m_row_reg};

endmodule

`default_nettype wire

// ----- hw/rtl/kms_checker.sv -----
// Port-level assertions for the keypad matrix scanner and their bind.
`default_nettype none

module kms_checker (
    input wire                               clk,
    input wire                               rst_n,
    input wire                               s_axis_tvalid,
    input wire                               s_axis_tready,
    input wire [kms_pkg::S_TDATA_WIDTH-1:0]  s_axis_tdata,
    input wire                               m_axis_tvalid,
    input wire                               m_axis_tready,
    input wire [kms_pkg::M_TDATA_WIDTH-1:0]  m_axis_tdata,
    input wire                               cfg_valid,
    input wire                               cfg_ready
);

    import kms_pkg::*;

    logic                  seen_reg;
    logic [MASK_WIDTH-1:0] prev_drive_reg;
    logic                  m_beat;

    assign m_beat = m_axis_tvalid && m_axis_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seen_reg       <= 1'b0;
            prev_drive_reg <= DRIVE_NONE;
        end
        else if (m_beat)
        begin
            seen_reg       <= 1'b1;
            prev_drive_reg <= m_axis_tdata[13:10];
        end
    end

    // A stalled result keeps its valid and its data.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("stalled output beat changed");

    // A sample that waits for the block keeps its valid and its data.
    assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && !s_axis_tready |=> s_axis_tvalid && $stable(s_axis_tdata))
    else $error("stalled input beat changed");

    // The input side only backs up behind a result that the receiver holds off.
    assert property (@(posedge clk) disable iff (!rst_n)
        !s_axis_tready |-> m_axis_tvalid && !m_axis_tready)
    else $error("input stalled without a waiting result");

    // Each result reports the row that the previous result said to drive next.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && seen_reg && prev_drive_reg != DRIVE_NONE
        |-> (~prev_drive_reg) == (4'b0001 << m_axis_tdata[1:0]))
    else $error("scanned row does not follow the previous drive pattern");

    // The configuration channel never pushes back.
    assert property (@(posedge clk) disable iff (!rst_n)
        cfg_valid |-> cfg_ready)
    else $error("configuration write stalled");

endmodule

bind keypad_matrix_scanner kms_checker u_kms_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready)
);

`default_nettype wire
